/* rtl/lvm_pkg.sv */
package lvm_pkg;

  // Fixed-point format of all vector entries.
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;

  // Signed width of the vectors that get normalized. The cross product
  // U x F is the widest of them.
  localparam int VEC_W  = WORD_W + FRAC_BITS + 3;
  localparam int MSB_W  = $clog2(VEC_W);

  // Normalizer internals: scaled magnitudes, sum of squares, root.
  localparam int NORM_W = 30;
  localparam int SUM_W  = 2 * NORM_W + 2;
  localparam int ROOT_W = NORM_W + 1;
  localparam int REM_W  = ROOT_W + 3;
  localparam int DR_W   = ROOT_W + 1;
  localparam int Q_W    = FRAC_BITS + 1;

  // Normalized component, corrected-up component and dot product widths.
  localparam int N_W    = FRAC_BITS + 2;
  localparam int V_W    = FRAC_BITS + 3;
  localparam int DOT_W  = WORD_W + V_W + 2;

  // Register stages from normalizer input to normalizer output.
  localparam int NORM_LAT = 5 + ROOT_W + Q_W + 1;

  localparam logic [WORD_W-1:0] ONE_FX = WORD_W'(1) << FRAC_BITS;

  localparam int IN_TDATA_W  = 9 * WORD_W;
  localparam int OUT_DATA_W  = 2 + 4 * WORD_W;
  localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [N_W-1:0]    nrm_t;

  typedef struct packed {
    logic vld;
    logic zero;
  } norm_ctl_t;

endpackage

/* rtl/look_at_view_matrix.sv */
// Channel   Dir  Transaction carries
// s_axis    in   tdata: pos x,y,z, target x,y,z, upvec x,y,z (32 bits each)
// m_axis    out  one matrix column; tuser: degenerate; tlast: final column
//
// The datapath is one stalled pipeline of 2 * NORM_LAT + 9 register stages
// (117 at sixteen fraction bits) with a valid bit in every stage.
// Each camera yields four output transactions, so the sustained rate is set by
// the column serializer at the output.
// When the serializer cannot take the next matrix, the whole pipeline holds.
// Reset clears only the valid bits and the serializer state.
module look_at_view_matrix import lvm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // pos_x, pos_y, pos_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // column, elem0, elem1, elem2, elem3, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // degenerate
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam int RS_W = DOT_W - FRAC_BITS;

  // Adds one half LSB and drops the fraction bits (round half up).
  function automatic logic signed [RS_W-1:0] rnd_sh(input logic signed [DOT_W-1:0] x);
    logic signed [DOT_W-1:0] t;
    t = x + (DOT_W'(1) << (FRAC_BITS - 1));
    return RS_W'(t >>> FRAC_BITS);
  endfunction

  // Negates and saturates to the 32-bit range.
  function automatic word_t neg_sat(input logic signed [RS_W-1:0] r);
    logic signed [RS_W:0] n;
    n = -(RS_W + 1)'(r);
    if (n[RS_W:WORD_W-1] == '0 || n[RS_W:WORD_W-1] == '1) begin
      return n[WORD_W-1:0];
    end
    return n[RS_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
  endfunction

  logic en;
  logic load;

  // Input stage and difference P - T.
  logic  v0_q, v1_q;
  word_t p0_q [3];
  word_t t0_q [3];
  word_t u0_q [3];
  word_t p1_q [3];
  word_t u1_q [3];
  vec_t  d1_q [3];

  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p0_q[k] <= s_axis_tdata_i[k*WORD_W +: WORD_W];
        t0_q[k] <= s_axis_tdata_i[(3+k)*WORD_W +: WORD_W];
        u0_q[k] <= s_axis_tdata_i[(6+k)*WORD_W +: WORD_W];
        d1_q[k] <= VEC_W'(p0_q[k]) - VEC_W'(t0_q[k]);
        p1_q[k] <= p0_q[k];
        u1_q[k] <= u0_q[k];
      end
    end
  end

  // Forward vector.
  nrm_t      fw_a [3];
  norm_ctl_t ctl_a;

  lvm_norm u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v1_q),
    .vec_i  (d1_q),
    .nrm_o  (fw_a),
    .ctl_o  (ctl_a)
  );

  word_t dla_p_q [NORM_LAT][3];
  word_t dla_u_q [NORM_LAT][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dla_p_q[0] <= p1_q;
      dla_u_q[0] <= u1_q;
      for (int s = 1; s < NORM_LAT; s++) begin
        dla_p_q[s] <= dla_p_q[s-1];
        dla_u_q[s] <= dla_u_q[s-1];
      end
    end
  end

  // Cross product U x F: products, then differences.
  logic                          v2_q, v3_q;
  logic signed [WORD_W+N_W-1:0]  pr2_q [6];
  word_t                         p2_q [3];
  word_t                         p3_q [3];
  nrm_t                          fw2_q [3];
  nrm_t                          fw3_q [3];
  logic                          z2_q, z3_q;
  vec_t                          cr3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v2_q <= ctl_a.vld;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr2_q[0] <= dla_u_q[NORM_LAT-1][1] * fw_a[2];
      pr2_q[1] <= dla_u_q[NORM_LAT-1][2] * fw_a[1];
      pr2_q[2] <= dla_u_q[NORM_LAT-1][2] * fw_a[0];
      pr2_q[3] <= dla_u_q[NORM_LAT-1][0] * fw_a[2];
      pr2_q[4] <= dla_u_q[NORM_LAT-1][0] * fw_a[1];
      pr2_q[5] <= dla_u_q[NORM_LAT-1][1] * fw_a[0];
      p2_q     <= dla_p_q[NORM_LAT-1];
      fw2_q    <= fw_a;
      z2_q     <= ctl_a.zero;
      for (int k = 0; k < 3; k++) begin
        cr3_q[k] <= VEC_W'(pr2_q[2*k]) - VEC_W'(pr2_q[2*k+1]);
      end
      p3_q  <= p2_q;
      fw3_q <= fw2_q;
      z3_q  <= z2_q;
    end
  end

  // Right vector.
  nrm_t      rt_b [3];
  norm_ctl_t ctl_b;

  lvm_norm u_norm_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v3_q),
    .vec_i  (cr3_q),
    .nrm_o  (rt_b),
    .ctl_o  (ctl_b)
  );

  word_t dlb_p_q  [NORM_LAT][3];
  nrm_t  dlb_fw_q [NORM_LAT][3];
  logic  dlb_z_q  [NORM_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlb_p_q[0]  <= p3_q;
      dlb_fw_q[0] <= fw3_q;
      dlb_z_q[0]  <= z3_q;
      for (int s = 1; s < NORM_LAT; s++) begin
        dlb_p_q[s]  <= dlb_p_q[s-1];
        dlb_fw_q[s] <= dlb_fw_q[s-1];
        dlb_z_q[s]  <= dlb_z_q[s-1];
      end
    end
  end

  // Corrected up and translation.
  logic                         v4_q, v5_q, v6_q, v7_q;
  logic signed [2*N_W-1:0]      fr4_q [6];
  logic signed [N_W+WORD_W-1:0] rp4_q [3];
  logic signed [N_W+WORD_W-1:0] fp4_q [3];
  word_t                        p4_q [3];
  word_t                        p5_q [3];
  nrm_t                         rt4_q [3];
  nrm_t                         rt5_q [3];
  nrm_t                         rt6_q [3];
  nrm_t                         rt7_q [3];
  nrm_t                         fw4_q [3];
  nrm_t                         fw5_q [3];
  nrm_t                         fw6_q [3];
  nrm_t                         fw7_q [3];
  logic signed [V_W-1:0]        vu5_q [3];
  logic signed [V_W-1:0]        vu6_q [3];
  logic signed [V_W-1:0]        vu7_q [3];
  logic signed [V_W+WORD_W-1:0] vp6_q [3];
  word_t                        tr0_5_q, tr2_5_q, tr0_6_q, tr2_6_q;
  word_t                        tr0_7_q, tr1_7_q, tr2_7_q;
  logic                         dg4_q, dg5_q, dg6_q, dg7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else if (en) begin
      v4_q <= ctl_b.vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr4_q[0] <= dlb_fw_q[NORM_LAT-1][1] * rt_b[2];
      fr4_q[1] <= dlb_fw_q[NORM_LAT-1][2] * rt_b[1];
      fr4_q[2] <= dlb_fw_q[NORM_LAT-1][2] * rt_b[0];
      fr4_q[3] <= dlb_fw_q[NORM_LAT-1][0] * rt_b[2];
      fr4_q[4] <= dlb_fw_q[NORM_LAT-1][0] * rt_b[1];
      fr4_q[5] <= dlb_fw_q[NORM_LAT-1][1] * rt_b[0];
      for (int k = 0; k < 3; k++) begin
        rp4_q[k] <= rt_b[k] * dlb_p_q[NORM_LAT-1][k];
        fp4_q[k] <= dlb_fw_q[NORM_LAT-1][k] * dlb_p_q[NORM_LAT-1][k];
      end
      p4_q  <= dlb_p_q[NORM_LAT-1];
      rt4_q <= rt_b;
      fw4_q <= dlb_fw_q[NORM_LAT-1];
      dg4_q <= dlb_z_q[NORM_LAT-1] | ctl_b.zero;

      for (int k = 0; k < 3; k++) begin
        vu5_q[k] <= V_W'(rnd_sh(DOT_W'(fr4_q[2*k]) - DOT_W'(fr4_q[2*k+1])));
      end
      tr0_5_q <= neg_sat(rnd_sh(DOT_W'(rp4_q[0]) + DOT_W'(rp4_q[1]) + DOT_W'(rp4_q[2])));
      tr2_5_q <= neg_sat(rnd_sh(DOT_W'(fp4_q[0]) + DOT_W'(fp4_q[1]) + DOT_W'(fp4_q[2])));
      p5_q  <= p4_q;
      rt5_q <= rt4_q;
      fw5_q <= fw4_q;
      dg5_q <= dg4_q;

      for (int k = 0; k < 3; k++) begin
        vp6_q[k] <= vu5_q[k] * p5_q[k];
      end
      vu6_q   <= vu5_q;
      rt6_q   <= rt5_q;
      fw6_q   <= fw5_q;
      tr0_6_q <= tr0_5_q;
      tr2_6_q <= tr2_5_q;
      dg6_q   <= dg5_q;

      tr1_7_q <= neg_sat(rnd_sh(DOT_W'(vp6_q[0]) + DOT_W'(vp6_q[1]) + DOT_W'(vp6_q[2])));
      vu7_q   <= vu6_q;
      rt7_q   <= rt6_q;
      fw7_q   <= fw6_q;
      tr0_7_q <= tr0_6_q;
      tr2_7_q <= tr2_6_q;
      dg7_q   <= dg6_q;
    end
  end

  // Column serializer. A finished matrix is taken when the holding register
  // is empty or its final column leaves in this cycle.
  logic       mat_vld_q;
  logic [1:0] col_q;
  word_t      m_rt_q [3];
  word_t      m_vu_q [3];
  word_t      m_fw_q [3];
  word_t      m_tr_q [3];
  logic       m_dg_q;
  word_t      e0, e1, e2, e3;
  logic       out_hs;

  assign out_hs = mat_vld_q & m_axis_tready_i;
  assign load   = v7_q & (~mat_vld_q | (out_hs & (col_q == 2'd3)));
  assign en     = ~v7_q | load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_vld_q <= 1'b0;
      col_q     <= '0;
    end else if (load) begin
      mat_vld_q <= 1'b1;
      col_q     <= '0;
    end else if (out_hs) begin
      if (col_q == 2'd3) mat_vld_q <= 1'b0;
      col_q <= col_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < 3; k++) begin
        m_rt_q[k] <= WORD_W'(rt7_q[k]);
        m_vu_q[k] <= WORD_W'(vu7_q[k]);
        m_fw_q[k] <= WORD_W'(fw7_q[k]);
      end
      m_tr_q[0] <= tr0_7_q;
      m_tr_q[1] <= tr1_7_q;
      m_tr_q[2] <= tr2_7_q;
      m_dg_q    <= dg7_q;
    end
  end

  always_comb begin
    unique case (col_q)
      2'd0: begin
        e0 = m_rt_q[0]; e1 = m_vu_q[0]; e2 = m_fw_q[0]; e3 = '0;
      end
      2'd1: begin
        e0 = m_rt_q[1]; e1 = m_vu_q[1]; e2 = m_fw_q[1]; e3 = '0;
      end
      2'd2: begin
        e0 = m_rt_q[2]; e1 = m_vu_q[2]; e2 = m_fw_q[2]; e3 = '0;
      end
      default: begin
        e0 = m_tr_q[0]; e1 = m_tr_q[1]; e2 = m_tr_q[2]; e3 = ONE_FX;
      end
    endcase
  end

  assign m_axis_tvalid_o = mat_vld_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-OUT_DATA_W){1'b0}}, e3, e2, e1, e0, col_q};
  assign m_axis_tuser_o  = m_dg_q;
  assign m_axis_tlast_o  = (col_q == 2'd3);

endmodule

/* rtl/lvm_norm.sv */
module lvm_norm import lvm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      vld_i,
  input  vec_t      vec_i [3],
  output nrm_t      nrm_o [3],
  output norm_ctl_t ctl_o
);

  function automatic logic [MSB_W-1:0] msb_idx(input logic [VEC_W-1:0] x);
    logic [MSB_W-1:0] r;
    r = '0;
    for (int b = 0; b < VEC_W; b++) begin
      if (x[b]) r = MSB_W'(b);
    end
    return r;
  endfunction

  // Front stages: magnitude, leading one, scaling, squares, sum.
  logic                v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [VEC_W-1:0]    a1_q [3];
  logic [VEC_W-1:0]    a2_q [3];
  logic                n1_q [3];
  logic                n2_q [3];
  logic                n3_q [3];
  logic                n4_q [3];
  logic                n5_q [3];
  logic [MSB_W-1:0]    msb2_q;
  logic                z2_q, z3_q, z4_q, z5_q;
  logic [NORM_W-1:0]   s3_q [3];
  logic [NORM_W-1:0]   s4_q [3];
  logic [NORM_W-1:0]   s5_q [3];
  logic [2*NORM_W-1:0] sq4_q [3];
  logic [SUM_W-1:0]    sum5_q;
  logic [VEC_W-1:0]    or2_d;
  logic [NORM_W-1:0]   s3_d [3];

  assign or2_d = a1_q[0] | a1_q[1] | a1_q[2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (msb2_q > MSB_W'(NORM_W - 1)) begin
        s3_d[k] = NORM_W'(a2_q[k] >> (msb2_q - MSB_W'(NORM_W - 1)));
      end else begin
        s3_d[k] = NORM_W'(a2_q[k] << (MSB_W'(NORM_W - 1) - msb2_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        n1_q[k]  <= vec_i[k][VEC_W-1];
        a1_q[k]  <= vec_i[k][VEC_W-1] ? VEC_W'(-vec_i[k]) : VEC_W'(vec_i[k]);
        a2_q[k]  <= a1_q[k];
        n2_q[k]  <= n1_q[k];
        s3_q[k]  <= s3_d[k];
        n3_q[k]  <= n2_q[k];
        sq4_q[k] <= s3_q[k] * s3_q[k];
        s4_q[k]  <= s3_q[k];
        n4_q[k]  <= n3_q[k];
        s5_q[k]  <= s4_q[k];
        n5_q[k]  <= n4_q[k];
      end
      msb2_q <= msb_idx(or2_d);
      z2_q   <= (or2_d == '0);
      z3_q   <= z2_q;
      z4_q   <= z3_q;
      z5_q   <= z4_q;
      sum5_q <= SUM_W'(sq4_q[0]) + SUM_W'(sq4_q[1]) + SUM_W'(sq4_q[2]);
    end
  end

  // Square root: one result bit per stage.
  logic              rv_q [ROOT_W];
  logic [SUM_W-1:0]  rx_q [ROOT_W];
  logic [REM_W-1:0]  rr_q [ROOT_W];
  logic [ROOT_W-1:0] rt_q [ROOT_W];
  logic [NORM_W-1:0] rs_q [ROOT_W][3];
  logic              rn_q [ROOT_W][3];
  logic              rz_q [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    logic              v_in, z_in;
    logic [SUM_W-1:0]  x_in;
    logic [REM_W-1:0]  r_in, r_sh, trial;
    logic [ROOT_W-1:0] t_in;
    logic [NORM_W-1:0] s_in [3];
    logic              n_in [3];

    if (i == 0) begin : g_first
      assign v_in = v5_q;
      assign z_in = z5_q;
      assign x_in = sum5_q;
      assign r_in = '0;
      assign t_in = '0;
      assign s_in = s5_q;
      assign n_in = n5_q;
    end else begin : g_next
      assign v_in = rv_q[i-1];
      assign z_in = rz_q[i-1];
      assign x_in = rx_q[i-1];
      assign r_in = rr_q[i-1];
      assign t_in = rt_q[i-1];
      assign s_in = rs_q[i-1];
      assign n_in = rn_q[i-1];
    end

    assign r_sh  = {r_in[REM_W-3:0], x_in[SUM_W-1-2*i -: 2]};
    assign trial = REM_W'({t_in, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[i] <= 1'b0;
      end else if (en_i) begin
        rv_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[i] <= x_in;
        rz_q[i] <= z_in;
        rs_q[i] <= s_in;
        rn_q[i] <= n_in;
        if (r_sh >= trial) begin
          rr_q[i] <= r_sh - trial;
          rt_q[i] <= {t_in[ROOT_W-2:0], 1'b1};
        end else begin
          rr_q[i] <= r_sh;
          rt_q[i] <= {t_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Division of each scaled magnitude by the length: one quotient bit per stage.
  logic              dv_q [Q_W];
  logic [ROOT_W-1:0] dl_q [Q_W];
  logic [DR_W-1:0]   dr_q [Q_W][3];
  logic [Q_W-1:0]    dq_q [Q_W][3];
  logic              dn_q [Q_W][3];
  logic              dz_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_div
    logic              v_in, z_in;
    logic [ROOT_W-1:0] l_in;
    logic [DR_W-1:0]   r_in [3];
    logic [Q_W-1:0]    q_in [3];
    logic              n_in [3];

    if (j == 0) begin : g_first
      assign v_in = rv_q[ROOT_W-1];
      assign z_in = rz_q[ROOT_W-1];
      assign l_in = rt_q[ROOT_W-1];
      assign n_in = rn_q[ROOT_W-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign r_in[k] = DR_W'(rs_q[ROOT_W-1][k]);
        assign q_in[k] = '0;
      end
    end else begin : g_next
      assign v_in = dv_q[j-1];
      assign z_in = dz_q[j-1];
      assign l_in = dl_q[j-1];
      assign n_in = dn_q[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign r_in[k] = {dr_q[j-1][k][DR_W-2:0], 1'b0};
        assign q_in[k] = dq_q[j-1][k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en_i) begin
        dv_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_q[j] <= l_in;
        dz_q[j] <= z_in;
        dn_q[j] <= n_in;
        for (int k = 0; k < 3; k++) begin
          if (r_in[k] >= DR_W'(l_in)) begin
            dr_q[j][k] <= r_in[k] - DR_W'(l_in);
            dq_q[j][k] <= {q_in[k][Q_W-2:0], 1'b1};
          end else begin
            dr_q[j][k] <= r_in[k];
            dq_q[j][k] <= {q_in[k][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Sign and zero-length handling.
  logic fv_q, fz_q;
  nrm_t nrm_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (en_i) begin
      fv_q <= dv_q[Q_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fz_q <= dz_q[Q_W-1];
      for (int k = 0; k < 3; k++) begin
        if (dz_q[Q_W-1]) begin
          nrm_q[k] <= '0;
        end else if (dn_q[Q_W-1][k]) begin
          nrm_q[k] <= -nrm_t'({1'b0, dq_q[Q_W-1][k]});
        end else begin
          nrm_q[k] <= nrm_t'({1'b0, dq_q[Q_W-1][k]});
        end
      end
    end
  end

  assign nrm_o     = nrm_q;
  assign ctl_o.vld = fv_q;
  assign ctl_o.zero = fz_q;

endmodule
